// ===== src/bigu_pkg.sv =====
// bigu_pkg: shared constants and types for the broadcast index generator
// no dependencies; imported by every bigu module and the top level
package bigu_pkg;

    localparam int REG_W     = 13;   // width of one dimension size register
    localparam int REG_DIMS  = 4;    // dimension registers per operand
    localparam int NUM_REGS  = 2 * REG_DIMS;
    localparam int CFG_IDX_W = 3;    // register index width
    localparam int IDX_W     = 48;   // linear index width
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 3 * IDX_W;

    // lane order inside the pipeline
    localparam int NUM_LANES  = 3;
    localparam int LANE_OUT   = 0;
    localparam int LANE_LEFT  = 1;
    localparam int LANE_RIGHT = 2;

    // register indexes of the first size of each operand
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_DIM0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DIM0 = 3'd4;

    typedef struct packed {
        logic last;
        logic shape_error;
    } meta_t;

endpackage

// ===== src/broadcast_index_generator_unit.sv =====
// broadcast_index_generator_unit: top level of the broadcast index generator
// depends on bigu_pkg, bigu_cfg_regs, bigu_coord_walker, bigu_horner_stage
// pipeline: walker register, then MAX_DIMS-1 multiply-add stages, the last of which is the
//   output register, and each stage fills bubbles independently under back-pressure
// throughput: one beat per cycle while m_tready is high
// reset: coordinates to zero, size registers to one, all pipeline stages empty
module broadcast_index_generator_unit #(
    parameter int MAX_DIMS = 4,
    parameter int DIM_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bigu_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [bigu_pkg::REG_W-1:0]        cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bigu_pkg::S_DATA_W-1:0]     s_tdata,   // restart, zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bigu_pkg::M_DATA_W-1:0]     m_tdata,   // out_index, left_index, right_index
    output logic                              m_tlast,   // last
    output logic                              m_tuser    // shape_error
);
    import bigu_pkg::*;

    localparam int SW = DIM_BITS + 1;

    logic [NUM_LANES-1:0][MAX_DIMS-1:0][SW-1:0] size;
    logic                                       shape_error;

    logic                                             pipe_valid [MAX_DIMS];
    logic                                             pipe_ready [MAX_DIMS];
    logic [NUM_LANES-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] pipe_coord [MAX_DIMS];
    logic [NUM_LANES-1:0][MAX_DIMS-1:0][SW-1:0]       pipe_size  [MAX_DIMS];
    logic [NUM_LANES-1:0][IDX_W-1:0]                  pipe_acc   [MAX_DIMS];
    meta_t                                            pipe_meta  [MAX_DIMS];

    bigu_cfg_regs #(
        .MAX_DIMS (MAX_DIMS),
        .DIM_BITS (DIM_BITS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .size        (size),
        .shape_error (shape_error)
    );

    bigu_coord_walker #(
        .MAX_DIMS (MAX_DIMS),
        .DIM_BITS (DIM_BITS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .restart     (s_tdata[0]),
        .size        (size),
        .shape_error (shape_error),
        .out_valid   (pipe_valid[0]),
        .out_ready   (pipe_ready[0]),
        .out_coord   (pipe_coord[0]),
        .out_size    (pipe_size[0]),
        .out_acc     (pipe_acc[0]),
        .out_meta    (pipe_meta[0])
    );

    for (genvar k = 1; k < MAX_DIMS; k++)
    begin : g_stage
        bigu_horner_stage #(
            .MAX_DIMS (MAX_DIMS),
            .DIM_BITS (DIM_BITS),
            .STEP     (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[k-1]),
            .in_ready  (pipe_ready[k-1]),
            .in_coord  (pipe_coord[k-1]),
            .in_size   (pipe_size[k-1]),
            .in_acc    (pipe_acc[k-1]),
            .in_meta   (pipe_meta[k-1]),
            .out_valid (pipe_valid[k]),
            .out_ready (pipe_ready[k]),
            .out_coord (pipe_coord[k]),
            .out_size  (pipe_size[k]),
            .out_acc   (pipe_acc[k]),
            .out_meta  (pipe_meta[k])
        );
    end

    assign pipe_ready[MAX_DIMS-1] = m_tready;
    assign m_tvalid = pipe_valid[MAX_DIMS-1];
    assign m_tdata  = {pipe_acc[MAX_DIMS-1][LANE_RIGHT],
                       pipe_acc[MAX_DIMS-1][LANE_LEFT],
                       pipe_acc[MAX_DIMS-1][LANE_OUT]};
    assign m_tlast  = pipe_meta[MAX_DIMS-1].last;
    assign m_tuser  = pipe_meta[MAX_DIMS-1].shape_error;

    // an empty output register frees the whole chain
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output register is empty");

endmodule

// ===== src/bigu_cfg_regs.sv =====
// bigu_cfg_regs: dimension size registers, effective per-position sizes and shape check
// depends on bigu_pkg
module bigu_cfg_regs #(
    parameter int MAX_DIMS = 4,
    parameter int DIM_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [bigu_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [bigu_pkg::REG_W-1:0]            cfg_wdata,
    output logic [bigu_pkg::NUM_LANES-1:0][MAX_DIMS-1:0][DIM_BITS:0] size,
    output logic                                  shape_error
);
    import bigu_pkg::*;

    localparam int SW = DIM_BITS + 1;
    localparam int CW = (REG_W > SW) ? REG_W : SW;
    localparam logic [CW-1:0] LIM = CW'(1) << DIM_BITS;

    logic [NUM_REGS-1:0][REG_W-1:0] cfg_reg;
    logic [MAX_DIMS-1:0][SW-1:0]    left_size;
    logic [MAX_DIMS-1:0][SW-1:0]    right_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= REG_W'(1);
            end
        end
        else if (cfg_wr_en)
        begin
            cfg_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // registers map to the innermost positions; extra outer positions are size one
    for (genvar p = 0; p < MAX_DIMS; p++)
    begin : g_pos
        localparam int R = p + REG_DIMS - MAX_DIMS;
        if (R < 0 || R >= REG_DIMS)
        begin : g_pad
            assign left_size[p]  = SW'(1);
            assign right_size[p] = SW'(1);
        end
        else
        begin : g_reg
            logic [CW-1:0] left_raw;
            logic [CW-1:0] right_raw;
            logic [CW-1:0] left_eff;
            logic [CW-1:0] right_eff;

            assign left_raw  = CW'(cfg_reg[int'(REG_LEFT_DIM0) + R]);
            assign right_raw = CW'(cfg_reg[int'(REG_RIGHT_DIM0) + R]);

            // zero acts as one, oversize clamps to the coordinate range
            always_comb
            begin
                if (left_raw == '0)
                    left_eff = CW'(1);
                else if (left_raw > LIM)
                    left_eff = LIM;
                else
                    left_eff = left_raw;

                if (right_raw == '0)
                    right_eff = CW'(1);
                else if (right_raw > LIM)
                    right_eff = LIM;
                else
                    right_eff = right_raw;
            end

            assign left_size[p]  = left_eff[SW-1:0];
            assign right_size[p] = right_eff[SW-1:0];
        end

        assign size[LANE_LEFT][p]  = left_size[p];
        assign size[LANE_RIGHT][p] = right_size[p];
        assign size[LANE_OUT][p]   = (left_size[p] == SW'(1)) ? right_size[p] : left_size[p];
    end

    always_comb
    begin
        shape_error = 1'b0;
        for (int p = 0; p < MAX_DIMS; p++)
        begin
            if (left_size[p] != SW'(1) && right_size[p] != SW'(1) &&
                left_size[p] != right_size[p])
                shape_error = 1'b1;
        end
    end

endmodule

// ===== src/bigu_coord_walker.sv =====
// bigu_coord_walker: coordinate state, row-major advance and the first pipeline register
// depends on bigu_pkg; sizes come from bigu_cfg_regs
module bigu_coord_walker #(
    parameter int MAX_DIMS = 4,
    parameter int DIM_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  restart,
    input  logic [bigu_pkg::NUM_LANES-1:0][MAX_DIMS-1:0][DIM_BITS:0] size,
    input  logic                                  shape_error,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bigu_pkg::NUM_LANES-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] out_coord,
    output logic [bigu_pkg::NUM_LANES-1:0][MAX_DIMS-1:0][DIM_BITS:0] out_size,
    output logic [bigu_pkg::NUM_LANES-1:0][bigu_pkg::IDX_W-1:0] out_acc,
    output bigu_pkg::meta_t                       out_meta
);
    import bigu_pkg::*;

    localparam int SW = DIM_BITS + 1;

    logic [NUM_LANES-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] coord_reg, coord_next, cur;
    logic [NUM_LANES-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] st_coord_reg;
    logic [NUM_LANES-1:0][MAX_DIMS-1:0][SW-1:0]       st_size_reg;
    logic [NUM_LANES-1:0][IDX_W-1:0]                  st_acc_reg, st_acc_next;
    meta_t                                            st_meta_reg, st_meta_next;
    logic                                             st_valid_reg;
    logic                                             accept;

    assign in_ready = !st_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic           carry;
        logic           is_last;
        logic [SW-1:0]  inc;
        logic [SW-1:0]  os_m1;

        cur        = restart ? '0 : coord_reg;
        coord_next = cur;
        carry      = 1'b1;
        is_last    = 1'b1;
        inc        = '0;
        os_m1      = '0;

        for (int p = 0; p < MAX_DIMS; p++)
        begin
            os_m1 = size[LANE_OUT][p] - SW'(1);
            if (cur[LANE_OUT][p] != os_m1[DIM_BITS-1:0])
                is_last = 1'b0;
        end

        // innermost first; a dimension that wraps clears all three coordinates
        for (int p = MAX_DIMS - 1; p >= 0; p--)
        begin
            if (carry)
            begin
                inc = {1'b0, cur[LANE_OUT][p]} + SW'(1);
                if (size[LANE_LEFT][p] != SW'(1))
                    coord_next[LANE_LEFT][p] = cur[LANE_LEFT][p] + DIM_BITS'(1);
                if (size[LANE_RIGHT][p] != SW'(1))
                    coord_next[LANE_RIGHT][p] = cur[LANE_RIGHT][p] + DIM_BITS'(1);
                if (inc < size[LANE_OUT][p])
                begin
                    coord_next[LANE_OUT][p] = inc[DIM_BITS-1:0];
                    carry = 1'b0;
                end
                else
                begin
                    coord_next[LANE_OUT][p]   = '0;
                    coord_next[LANE_LEFT][p]  = '0;
                    coord_next[LANE_RIGHT][p] = '0;
                end
            end
        end

        for (int l = 0; l < NUM_LANES; l++)
        begin
            st_acc_next[l] = IDX_W'(cur[l][0]);
        end
        st_meta_next.last        = is_last;
        st_meta_next.shape_error = shape_error;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_reg    <= '0;
            st_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                coord_reg <= coord_next;
            if (in_ready)
                st_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_coord_reg <= cur;
            st_size_reg  <= size;
            st_acc_reg   <= st_acc_next;
            st_meta_reg  <= st_meta_next;
        end
    end

    assign out_valid = st_valid_reg;
    assign out_coord = st_coord_reg;
    assign out_size  = st_size_reg;
    assign out_acc   = st_acc_reg;
    assign out_meta  = st_meta_reg;

    a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && restart |=> st_coord_reg == '0 && st_acc_reg == '0)
        else $error("restart beat did not start from the first element");

    a_coord_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(coord_reg))
        else $error("coordinates moved without an accepted beat");

endmodule

// ===== src/bigu_horner_stage.sv =====
// bigu_horner_stage: one registered multiply-add step of the linear index, three lanes
// depends on bigu_pkg
module bigu_horner_stage #(
    parameter int MAX_DIMS = 4,
    parameter int DIM_BITS = 12,
    parameter int STEP     = 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [bigu_pkg::NUM_LANES-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] in_coord,
    input  logic [bigu_pkg::NUM_LANES-1:0][MAX_DIMS-1:0][DIM_BITS:0] in_size,
    input  logic [bigu_pkg::NUM_LANES-1:0][bigu_pkg::IDX_W-1:0] in_acc,
    input  bigu_pkg::meta_t                       in_meta,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bigu_pkg::NUM_LANES-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] out_coord,
    output logic [bigu_pkg::NUM_LANES-1:0][MAX_DIMS-1:0][DIM_BITS:0] out_size,
    output logic [bigu_pkg::NUM_LANES-1:0][bigu_pkg::IDX_W-1:0] out_acc,
    output bigu_pkg::meta_t                       out_meta
);
    import bigu_pkg::*;

    localparam int SW = DIM_BITS + 1;

    logic [NUM_LANES-1:0][IDX_W+SW-1:0]               prod;
    logic [NUM_LANES-1:0][IDX_W-1:0]                  acc_next, acc_reg;
    logic [NUM_LANES-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] coord_reg;
    logic [NUM_LANES-1:0][MAX_DIMS-1:0][SW-1:0]       size_reg;
    meta_t                                            meta_reg;
    logic                                             valid_reg;

    assign in_ready = !valid_reg || out_ready;

    // index = index * size + coord, taken modulo 2^48
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            prod[l]     = in_acc[l] * in_size[l][STEP];
            acc_next[l] = prod[l][IDX_W-1:0] + IDX_W'(in_coord[l][STEP]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            acc_reg   <= acc_next;
            coord_reg <= in_coord;
            size_reg  <= in_size;
            meta_reg  <= in_meta;
        end
    end

    assign out_valid = valid_reg;
    assign out_coord = coord_reg;
    assign out_size  = size_reg;
    assign out_acc   = acc_reg;
    assign out_meta  = meta_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(acc_reg) && $stable(meta_reg))
        else $error("stalled stage lost or changed its beat");

endmodule

// ===== sim/broadcast_index_generator_unit_tb.sv =====
// self-checking testbench for broadcast_index_generator_unit: predicts every address triple
// from its own walk of the broadcast coordinates and checks each result beat in order
// depends on bigu_pkg and the broadcast_index_generator_unit rtl
`timescale 1ns / 100ps

module broadcast_index_generator_unit_tb;

    import bigu_pkg::*;

    localparam int                NDIMS    = 4;
    localparam logic [REG_W-1:0]  MAX_SIZE = 13'd4096;
    localparam int                MAX_SHOW = 10;

    // load_shapes sizes: dim0 (outermost) in the top slot so {d0, d1, d2, d3} reads naturally
    typedef logic [NDIMS-1:0][REG_W-1:0] shape_t;
    typedef logic [NDIMS-1:0][11:0]      coord_t;

    typedef struct packed {
        logic [IDX_W-1:0] out_idx;
        logic [IDX_W-1:0] left_idx;
        logic [IDX_W-1:0] right_idx;
        logic             last;
        logic             shape_err;
    } element_addr_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [REG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    broadcast_index_generator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // walk state and size registers as the block should hold them
    shape_t left_regs  = {NDIMS{13'd1}};
    shape_t right_regs = {NDIMS{13'd1}};
    coord_t walk_out   = '0;
    coord_t walk_left  = '0;
    coord_t walk_right = '0;

    bit            restart_queue[$];
    element_addr_t pending_addrs[$];
    int unsigned   send_gap      = 0;
    int unsigned   recv_stall    = 0;
    bit            steady        = 1'b0;
    int unsigned   addr_mismatches = 0;
    int unsigned   stray_beats     = 0;

    function automatic logic [REG_W-1:0] eff_size(logic [REG_W-1:0] raw);
        if (raw == '0)
            return 13'd1;
        if (raw > MAX_SIZE)
            return MAX_SIZE;
        return raw;
    endfunction

    // position 0 is the outermost dimension, the stride grows from the innermost one
    function automatic logic [IDX_W-1:0] flat_index(coord_t c, shape_t s);
        logic [63:0] acc;
        logic [63:0] stride;
        acc    = '0;
        stride = 64'd1;
        for (int p = NDIMS - 1; p >= 0; p--)
        begin
            acc    = acc + stride * c[p];
            stride = stride * s[p];
        end
        return acc[IDX_W-1:0];
    endfunction

    // emit the current element, then advance the walk (innermost dimension first)
    function automatic element_addr_t walk_step(bit restart);
        shape_t        ls;
        shape_t        rs;
        shape_t        os;
        element_addr_t e;
        logic          err;
        logic          fin;
        logic          done;
        int unsigned   nxt;
        err  = 1'b0;
        fin  = 1'b1;
        done = 1'b0;
        for (int p = 0; p < NDIMS; p++)
        begin
            ls[p] = eff_size(left_regs[p]);
            rs[p] = eff_size(right_regs[p]);
            os[p] = (ls[p] == 13'd1) ? rs[p] : ls[p];
            if (ls[p] != 13'd1 && rs[p] != 13'd1 && ls[p] != rs[p])
                err = 1'b1;
        end
        if (restart)
        begin
            walk_out   = '0;
            walk_left  = '0;
            walk_right = '0;
        end
        for (int p = 0; p < NDIMS; p++)
            if ({1'b0, walk_out[p]} != os[p] - 13'd1)
                fin = 1'b0;
        e.out_idx   = flat_index(walk_out, os);
        e.left_idx  = flat_index(walk_left, ls);
        e.right_idx = flat_index(walk_right, rs);
        e.last      = fin;
        e.shape_err = err;
        for (int p = NDIMS - 1; p >= 0; p--)
            if (!done)
            begin
                nxt = walk_out[p] + 1;
                // source coordinates only move where that operand is not broadcast
                if (ls[p] > 13'd1)
                    walk_left[p] = walk_left[p] + 12'd1;
                if (rs[p] > 13'd1)
                    walk_right[p] = walk_right[p] + 12'd1;
                if (nxt < os[p])
                begin
                    walk_out[p] = nxt[11:0];
                    done        = 1'b1;
                end
                else
                begin
                    walk_out[p]   = '0;
                    walk_left[p]  = '0;
                    walk_right[p] = '0;
                end
            end
        return e;
    endfunction

    // stimulus driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pending_addrs.push_back(walk_step(s_tdata[0]));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (restart_queue.size() > 0)
                begin
                    s_tdata  <= {{(S_DATA_W-1){1'b0}}, restart_queue.pop_front()};
                    s_tvalid <= 1'b1;
                    send_gap = steady ? 0 : $urandom_range(0, 7);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        element_addr_t got;
        element_addr_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.out_idx   = m_tdata[IDX_W-1:0];
                got.left_idx  = m_tdata[2*IDX_W-1:IDX_W];
                got.right_idx = m_tdata[3*IDX_W-1:2*IDX_W];
                got.last      = m_tlast;
                got.shape_err = m_tuser;
                if (pending_addrs.size() == 0)
                begin
                    if (addr_mismatches + stray_beats < MAX_SHOW)
                        $display("%0t: unexpected beat out=%0h left=%0h right=%0h last=%b err=%b",
                                 $realtime, got.out_idx, got.left_idx, got.right_idx,
                                 got.last, got.shape_err);
                    stray_beats++;
                end
                else
                begin
                    want = pending_addrs.pop_front();
                    if (got.out_idx != want.out_idx || got.left_idx != want.left_idx ||
                        got.right_idx != want.right_idx || got.last != want.last ||
                        got.shape_err != want.shape_err)
                    begin
                        if (addr_mismatches + stray_beats < MAX_SHOW)
                        begin
                            $display("%0t: mismatch exp out=%0h left=%0h right=%0h last=%b err=%b",
                                     $realtime, want.out_idx, want.left_idx, want.right_idx,
                                     want.last, want.shape_err);
                            $display("%0t:          got out=%0h left=%0h right=%0h last=%b err=%b",
                                     $realtime, got.out_idx, got.left_idx, got.right_idx,
                                     got.last, got.shape_err);
                        end
                        addr_mismatches++;
                    end
                end
                recv_stall = steady ? 0 : $urandom_range(0, 7);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (restart_queue.size() > 0 || s_tvalid || pending_addrs.size() > 0);
    endtask

    // only called with the block idle
    task automatic load_shapes(shape_t l, shape_t r);
        for (int i = 0; i < NDIMS; i++)
        begin
            @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_addr  <= REG_LEFT_DIM0 + CFG_IDX_W'(i);
            cfg_wdata <= l[NDIMS-1-i];
            left_regs[i] = l[NDIMS-1-i];
        end
        for (int i = 0; i < NDIMS; i++)
        begin
            @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_addr  <= REG_RIGHT_DIM0 + CFG_IDX_W'(i);
            cfg_wdata <= r[NDIMS-1-i];
            right_regs[i] = r[NDIMS-1-i];
        end
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send(bit restart, int count);
        for (int k = 0; k < count; k++)
            restart_queue.push_back(restart);
    endtask

    function automatic logic [REG_W-1:0] rand_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 9)
            return MAX_SIZE;
        if (r < 12)
            return REG_W'($urandom_range(4097, 8191));
        if (r < 15)
            return REG_W'($urandom_range(5, 40));
        return REG_W'($urandom_range(1, 3));
    endfunction

    task automatic random_shapes();
        shape_t      l;
        shape_t      r;
        int unsigned pick;
        for (int i = 0; i < NDIMS; i++)
        begin
            l[i] = rand_size();
            pick = $urandom_range(0, 3);
            // mostly compatible pairs, some broadcast, some clashing
            if (pick < 2)
                r[i] = l[i];
            else if (pick == 2)
                r[i] = 13'd1;
            else
                r[i] = rand_size();
        end
        load_shapes(l, r);
    endtask

    initial
    begin
        int unsigned random_sent;
        int unsigned n;
        random_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset shapes: a single element walk, every beat is last
        send(1'b0, 1);
        send(1'b1, 1);
        wait_idle();

        // left broadcast in dims 0 and 2, right in dim 1
        load_shapes({13'd1, 13'd3, 13'd1, 13'd4}, {13'd2, 13'd1, 13'd5, 13'd4});
        send(1'b1, 1);
        send(1'b0, 4);
        wait_idle();

        // clashing sizes raise shape_error
        load_shapes({13'd2, 13'd3, 13'd1, 13'd1}, {13'd3, 13'd3, 13'd1, 13'd2});
        send(1'b1, 1);
        send(1'b0, 2);
        wait_idle();

        // zero acts as one, oversize clamps to the max size
        load_shapes({13'd0, 13'd8191, 13'd2, 13'd0}, {13'd1, MAX_SIZE, 13'd0, 13'd3});
        send(1'b1, 1);
        send(1'b0, 2);
        wait_idle();

        // four element walk, runs past last and wraps to the first element
        load_shapes({13'd1, 13'd1, 13'd2, 13'd2}, {13'd1, 13'd1, 13'd1, 13'd1});
        send(1'b1, 1);
        send(1'b0, 5);
        wait_idle();

        // largest shapes, walk carried over from the previous setting first
        load_shapes({NDIMS{MAX_SIZE}}, {NDIMS{MAX_SIZE}});
        send(1'b0, 2);
        send(1'b1, 1);
        wait_idle();

        while (random_sent < 1450)
        begin
            steady = ($urandom_range(0, 3) == 0);
            random_shapes();
            n = $urandom_range(40, 120);
            restart_queue.push_back($urandom_range(0, 1) == 1);
            for (int k = 1; k < n; k++)
                restart_queue.push_back($urandom_range(0, 19) == 0);
            random_sent += n;
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (addr_mismatches == 0 && stray_beats == 0 && pending_addrs.size() == 0)
            $display("broadcast_index_generator_unit regression: pass");
        else
            $display("broadcast_index_generator_unit regression: fail");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("broadcast_index_generator_unit regression: fail");
        $finish;
    end

endmodule

// ===== broadcast_index_generator_unit.f =====
src/bigu_pkg.sv
src/bigu_cfg_regs.sv
src/bigu_coord_walker.sv
src/bigu_horner_stage.sv
src/broadcast_index_generator_unit.sv
sim/broadcast_index_generator_unit_tb.sv
